// ===== sv/ctp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg
// Types, codes and constants shared by the chain topology table modules.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = 8;

  localparam logic [ADDR_W-1:0] MAX_ADDRESS   = 8'd15;
  localparam logic [ADDR_W-1:0] EMPTY_ADDRESS = 8'hFF;
  localparam logic [CNT_W-1:0]  FULL_COUNT    = CNT_W'(SLOTS);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] module_address;
    logic              same_orientation;
    logic [IDX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CNT_W-1:0]  module_total;
    logic [CNT_W-1:0]  pitch_total;
    logic [ADDR_W-1:0] entry_address;
    logic              entry_pitch;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       idx_zero;
    logic       idx_tail;
    logic       idx_read;
    logic       idx_inc;
    logic       idx_dec;
    logic       append;
    logic       clear;
    logic       set_status;
    logic [1:0] status_val;
    logic       reply;
  } ctp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       reject;
    logic       single;
    logic       match;
    logic       idx_last;
    logic       idx_one;
  } ctp_stat_t;

endpackage
`default_nettype wire

// ===== sv/chain_topology_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chain_topology_table
// Ordered table of chained modules with append, tail removal and read.
// ----------------------------------------------------------------------------
// read, rejected append, unused command and single-entry remove: decode state, then reply
// append: decode, a duplicate scan of one entry per cycle, then append and reply
// remove: decode, then a walk from the tail clearing entries, then reply
// one item at a time; busy stays high until the result strobe cycle
// the result is shown for one cycle and cannot be held off by the receiver
// reset: async active low, table back to master only, counts 1 and 0
module chain_topology_table import ctp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire item_t item_i,
  output logic       busy,
  output logic       result_valid_o,
  output result_t    result_o
);

  ctp_ctrl_t ctrl;
  ctp_stat_t stat;

  ctp_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  ctp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ===== sv/ctp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_datapath
// Slot table, counts, walk index and result register.
// ----------------------------------------------------------------------------
module ctp_datapath import ctp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire item_t     item_i,
  input  wire ctp_ctrl_t ctrl_i,
  output ctp_stat_t      stat_o,
  output logic           result_valid_o,
  output result_t        result_o
);

  item_t             item_q;
  logic [ADDR_W-1:0] slot_addr_q [SLOTS];
  logic              slot_pitch_q [SLOTS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pcount_q, pcount_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [1:0]        status_q, status_d;
  logic              res_valid_q;
  result_t           res_q, res_d;

  logic [ADDR_W-1:0] rd_addr;
  logic              rd_pitch;
  logic              new_pitch;
  logic [CNT_W-1:0]  tail;
  logic [IDX_W-1:0]  wr_idx;

  // single read port at the walk index
  assign rd_addr   = slot_addr_q[idx_q];
  assign rd_pitch  = slot_pitch_q[idx_q];
  assign tail      = count_q - CNT_W'(1);
  assign wr_idx    = count_q[IDX_W-1:0];
  assign new_pitch = item_q.same_orientation ? rd_pitch : ~rd_pitch;

  assign stat_o.cmd      = item_q.cmd;
  assign stat_o.reject   = (item_q.module_address == '0)
                        || (item_q.module_address > MAX_ADDRESS)
                        || (count_q == FULL_COUNT);
  assign stat_o.single   = (count_q == CNT_W'(1));
  assign stat_o.match    = (rd_addr == item_q.module_address);
  assign stat_o.idx_last = ({1'b0, idx_q} == tail);
  assign stat_o.idx_one  = (idx_q == IDX_W'(1));

  always_comb begin
    idx_d = idx_q;
    priority if (ctrl_i.idx_zero) begin
      idx_d = '0;
    end else if (ctrl_i.idx_tail) begin
      idx_d = tail[IDX_W-1:0];
    end else if (ctrl_i.idx_read) begin
      idx_d = item_q.read_index;
    end else if (ctrl_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end else if (ctrl_i.idx_dec) begin
      idx_d = idx_q - IDX_W'(1);
    end
  end

  always_comb begin
    count_d  = count_q;
    pcount_d = pcount_q;
    if (ctrl_i.append) begin
      count_d  = count_q + CNT_W'(1);
      pcount_d = pcount_q + CNT_W'(new_pitch);
    end else if (ctrl_i.clear) begin
      count_d  = {1'b0, idx_q};
      pcount_d = pcount_q - CNT_W'(rd_pitch);
    end
  end

  always_comb begin
    status_d = status_q;
    if (ctrl_i.load) begin
      status_d = STATUS_OK;
    end else if (ctrl_i.set_status) begin
      status_d = ctrl_i.status_val;
    end
  end

  always_comb begin
    res_d               = '0;
    res_d.status        = status_q;
    res_d.module_total  = count_q;
    res_d.pitch_total   = pcount_q;
    if (item_q.cmd == CMD_READ) begin
      res_d.entry_address = rd_addr;
      res_d.entry_pitch   = rd_pitch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_addr_q[i]  <= (i == 0) ? '0 : EMPTY_ADDRESS;
        slot_pitch_q[i] <= (i != 0);
      end
      count_q     <= CNT_W'(1);
      pcount_q    <= '0;
      idx_q       <= '0;
      status_q    <= STATUS_OK;
      res_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.append) begin
        slot_addr_q[wr_idx]  <= item_q.module_address;
        slot_pitch_q[wr_idx] <= new_pitch;
      end else if (ctrl_i.clear) begin
        slot_addr_q[idx_q]  <= EMPTY_ADDRESS;
        slot_pitch_q[idx_q] <= 1'b1;
      end
      count_q     <= count_d;
      pcount_q    <= pcount_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      res_valid_q <= ctrl_i.reply;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= item_i;
    end
    if (ctrl_i.reply) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(1)) && (count_q <= FULL_COUNT))
    else $error("module count out of range");

  a_pitch_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q < count_q)
    else $error("pitch count not below module count");

  a_master_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_addr_q[0] == '0) && !slot_pitch_q[0])
    else $error("master entry changed");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.append && ctrl_i.clear))
    else $error("append and clear in one cycle");

  a_clear_not_master: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |-> (idx_q != '0))
    else $error("clear aimed at master entry");

endmodule
`default_nettype wire

// ===== sv/ctp_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_controller
// Sequences append scans, tail removal walks, reads and replies.
// ----------------------------------------------------------------------------
module ctp_controller import ctp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire ctp_stat_t stat_i,
  output logic           busy,
  output ctp_ctrl_t      ctrl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_REMOVE = 3'd4;
  localparam logic [2:0] S_REPLY  = 3'd5;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_APPEND: begin
            if (stat_i.reject) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status_val = STATUS_INVALID;
              state_d           = S_REPLY;
            end else begin
              ctrl_o.idx_zero = 1'b1;
              state_d         = S_SCAN;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.single) begin
              state_d = S_REPLY;
            end else begin
              ctrl_o.idx_tail = 1'b1;
              state_d         = S_REMOVE;
            end
          end
          CMD_READ: begin
            ctrl_o.idx_read = 1'b1;
            state_d         = S_REPLY;
          end
          default: begin
            state_d = S_REPLY;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.match) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status_val = STATUS_DUPLICATE;
          state_d           = S_REPLY;
        end else if (stat_i.idx_last) begin
          state_d = S_APPEND;
        end else begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      S_APPEND: begin
        ctrl_o.append = 1'b1;
        state_d       = S_REPLY;
      end
      S_REMOVE: begin
        if (stat_i.match) begin
          state_d = S_REPLY;
        end else begin
          ctrl_o.clear = 1'b1;
          if (stat_i.idx_one) begin
            state_d = S_REPLY;
          end else begin
            ctrl_o.idx_dec = 1'b1;
          end
        end
      end
      S_REPLY: begin
        ctrl_o.reply = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> (state_q == S_IDLE))
    else $error("item loaded while busy");

  a_reply_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.reply |=> !busy)
    else $error("still busy after reply");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

endmodule
`default_nettype wire

// ===== bench/chain_topology_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chain_topology_table_tb
// Drives append, remove, read and unused commands into the chain table,
// predicts every reply from a local copy of the table and compares each
// strobed result field by field, in order, with the predicted reply.
// ----------------------------------------------------------------------------
module chain_topology_table_tb;
  import ctp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 25;
  localparam int MAX_PRINTED = 50;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   cmd_item = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  // local copy of the chain
  logic [ADDR_W-1:0] chain_addr [SLOTS];
  logic              chain_pitch [SLOTS];
  logic [CNT_W-1:0]  chain_len;
  logic [CNT_W-1:0]  pitch_len;

  result_t pending_results[$];
  int      err_cnt = 0;
  int      burst_left = 0;
  int      stall_cycles = 0;

  chain_topology_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (cmd_item),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic reset_chain();
    for (int i = 0; i < SLOTS; i++) begin
      chain_addr[i]  = EMPTY_ADDRESS;
      chain_pitch[i] = 1'b1;
    end
    chain_addr[0]  = '0;
    chain_pitch[0] = 1'b0;
    chain_len      = CNT_W'(1);
    pitch_len      = '0;
  endtask

  task automatic recount_pitch();
    pitch_len = '0;
    for (int i = 0; i < chain_len && i < SLOTS; i++) begin
      pitch_len = pitch_len + chain_pitch[i];
    end
  endtask

  task automatic apply_to_chain(input item_t it, output result_t res);
    logic found;
    int   i;
    found = 1'b0;
    res = '0;
    res.status = STATUS_OK;
    case (it.cmd)
      CMD_APPEND: begin
        if (it.module_address < 1 || it.module_address > MAX_ADDRESS ||
            chain_len >= FULL_COUNT) begin
          res.status = STATUS_INVALID;
        end else begin
          for (i = 0; i < chain_len; i++) begin
            if (chain_addr[i] == it.module_address) found = 1'b1;
          end
          if (found) begin
            res.status = STATUS_DUPLICATE;
          end else begin
            chain_addr[chain_len]  = it.module_address;
            chain_pitch[chain_len] = it.same_orientation ? chain_pitch[chain_len-1]
                                                         : ~chain_pitch[chain_len-1];
            chain_len = chain_len + 1'b1;
            recount_pitch();
          end
        end
      end
      CMD_REMOVE: begin
        i = chain_len;
        while (i > 1) begin
          i--;
          if (chain_addr[i] == it.module_address) break;
          chain_addr[i]  = EMPTY_ADDRESS;
          chain_pitch[i] = 1'b1;
          chain_len = CNT_W'(i);
        end
        recount_pitch();
      end
      CMD_READ: begin
        res.entry_address = chain_addr[it.read_index];
        res.entry_pitch   = chain_pitch[it.read_index];
      end
      default: ;
    endcase
    res.module_total = chain_len;
    res.pitch_total  = pitch_len;
  endtask

  function automatic item_t make_item(logic [1:0] c, logic [ADDR_W-1:0] a, logic s,
                                      logic [IDX_W-1:0] x);
    item_t it;
    it.cmd              = c;
    it.module_address   = a;
    it.same_orientation = s;
    it.read_index       = x;
    return it;
  endfunction

  // start stays high across back-to-back items, lowered only for a gap
  task automatic send_item(input item_t it);
    result_t want;
    start    <= 1'b1;
    cmd_item <= it;
    do @(posedge clk_i); while (busy);
    apply_to_chain(it, want);
    pending_results.push_back(want);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    if (err_cnt < MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    end
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", result_o.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch("status", result_o.status, want.status);
        if (result_o.module_total !== want.module_total)
          report_mismatch("module_total", result_o.module_total, want.module_total);
        if (result_o.pitch_total !== want.pitch_total)
          report_mismatch("pitch_total", result_o.pitch_total, want.pitch_total);
        if (result_o.entry_address !== want.entry_address)
          report_mismatch("entry_address", result_o.entry_address, want.entry_address);
        if (result_o.entry_pitch !== want.entry_pitch)
          report_mismatch("entry_pitch", result_o.entry_pitch, want.entry_pitch);
      end
    end
  end

  // watchdog on cycles with no item and no result accepted
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_reads();
    send_item(make_item(CMD_READ, 8'h00, 1'b0, 4'd0));
    send_item(make_item(CMD_READ, 8'hFF, 1'b1, 4'd15));
  endtask

  task automatic test_bad_address();
    send_item(make_item(CMD_APPEND, 8'd0, 1'b1, 4'd3));
    send_item(make_item(CMD_APPEND, 8'd16, 1'b0, 4'd0));
    send_item(make_item(CMD_APPEND, 8'd255, 1'b1, 4'd15));
  endtask

  task automatic test_fill_table();
    for (int a = 1; a <= 15; a++) begin
      send_item(make_item(CMD_APPEND, ADDR_W'(a), a[0], ~IDX_W'(a)));
    end
    send_item(make_item(CMD_APPEND, 8'd8, 1'b1, 4'd0));
    send_item(make_item(CMD_READ, 8'd0, 1'b0, 4'd15));
  endtask

  task automatic test_remove();
    send_item(make_item(CMD_REMOVE, 8'd12, 1'b0, 4'd0));
    send_item(make_item(CMD_APPEND, 8'd12, 1'b1, 4'd0));
    send_item(make_item(CMD_REMOVE, 8'd200, 1'b1, 4'd9));
  endtask

  task automatic test_unused_cmd();
    send_item(make_item(CMD_UNUSED, 8'hFF, 1'b1, 4'hF));
  endtask

  task automatic test_random_traffic(input int n_items);
    item_t it;
    int    pick;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      it = make_item(CMD_READ, ADDR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     IDX_W'($urandom_range(0, 15)));
      if (pick < 45) begin
        it.cmd = CMD_APPEND;
        if ($urandom_range(0, 9) < 8) it.module_address = ADDR_W'($urandom_range(1, 15));
      end else if (pick < 60) begin
        it.cmd = CMD_REMOVE;
        if (chain_len > 1 && $urandom_range(0, 9) < 8)
          it.module_address = chain_addr[$urandom_range(1, chain_len - 1)];
      end else if (pick >= 92) begin
        it.cmd = CMD_UNUSED;
      end
      send_item(it);
    end
  endtask

  initial begin
    reset_chain();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_bad_address();
    test_fill_table();
    test_remove();
    test_unused_cmd();
    test_random_traffic(450);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
